// ===== hw/rtl/qslerp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the quaternion slerp pipeline.
// No dependencies; every other file refers to it by scoped names.
package qslerp_pkg;

  localparam int COMP_FRAC_BITS = 14;
  localparam int TRIG_ITER_DEF  = 16;
  localparam int TRIG_ITER_MAX  = 32;
  localparam int CORDIC_W       = 36;
  localparam int CORDIC_FRAC    = 30;
  localparam int SINE_W         = 33;
  localparam int QUOT_W         = 16;
  localparam int DIV_STAGES     = QUOT_W + 1;
  localparam int DIV_NUM_W      = 51;
  localparam int DEN_W          = 31;
  localparam int THETA_W        = 14;
  localparam int FRAC_W         = 17;
  localparam int DIST_W         = 15;
  localparam int THR_W          = 8;
  localparam int LANES          = 4;

  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
  localparam logic [THR_W-1:0]  THR_RESET = 8'd1;

  // configuration register indexes
  localparam logic CFG_SMALL_ANGLE = 1'b0;
  localparam logic CFG_PARALLEL    = 1'b1;

  typedef logic signed [CORDIC_W-1:0] cw_t;
  typedef logic signed [15:0] comp_t;

  typedef struct packed {
    comp_t              start_x;
    comp_t              start_y;
    comp_t              start_z;
    comp_t              start_w;
    comp_t              end_x;
    comp_t              end_y;
    comp_t              end_z;
    comp_t              end_w;
    logic [FRAC_W-1:0]  fraction;
  } in_t;

  typedef struct packed {
    comp_t              out_x;
    comp_t              out_y;
    comp_t              out_z;
    comp_t              out_w;
    logic [DIST_W-1:0]  rotation_distance;
    logic               copied_start;
  } out_t;

  // per-request control and operands that ride along the pipeline
  typedef struct packed {
    logic [LANES-1:0][15:0]    qa;
    logic [LANES-1:0][15:0]    qb;
    logic [FRAC_W-1:0]         frac;
    logic                      neg;
    logic [COMP_FRAC_BITS:0]   mag;
    logic                      par;
    logic [DIST_W-1:0]         rot_dist;
    logic                      copy;
  } side_t;

  // arctangent of 2^-i, 30 fraction bits, truncated
  localparam logic [31:0] ATAN_Q30 [TRIG_ITER_MAX] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage

// ===== hw/rtl/qslerp_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Depends on qslerp_pkg.
module qslerp_isqrt (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic [2*qslerp_pkg::COMP_FRAC_BITS+1:0] in_rad,
  input  qslerp_pkg::side_t                     in_side,
  output logic                                  out_valid,
  output logic [qslerp_pkg::COMP_FRAC_BITS:0]   out_root,
  output qslerp_pkg::side_t                     out_side
);

  localparam int F  = qslerp_pkg::COMP_FRAC_BITS;
  localparam int NS = F + 1;
  localparam int RW = 2 * F + 2;

  logic [RW-1:0]     rem_r  [NS];
  logic [RW-1:0]     root_r [NS];
  logic              vld_r  [NS];
  qslerp_pkg::side_t side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (F - s));
    logic [RW-1:0]     rem_in;
    logic [RW-1:0]     root_in;
    logic              vld_in;
    qslerp_pkg::side_t side_in;
    logic [RW-1:0]     trial;
    logic [RW-1:0]     rem_nxt;
    logic [RW-1:0]     root_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign vld_in  = vld_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      trial = root_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = (root_in >> 1) + BIT;
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
      rem_r[s]  <= rem_nxt;
      root_r[s] <= root_nxt;
      side_r[s] <= side_in;
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_root  = root_r[NS-1][F:0];
  assign out_side  = side_r[NS-1];

endmodule

// ===== hw/rtl/qslerp_vcordic.sv =====
`timescale 1ns / 1ps
// Vectoring CORDIC, one micro-rotation per stage: angle of (x, y).
// Depends on qslerp_pkg.
module qslerp_vcordic #(
  parameter int ITER = qslerp_pkg::TRIG_ITER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  qslerp_pkg::cw_t   in_x,
  input  qslerp_pkg::cw_t   in_y,
  input  qslerp_pkg::side_t in_side,
  output logic              out_valid,
  output qslerp_pkg::cw_t   out_z,
  output qslerp_pkg::side_t out_side
);

  qslerp_pkg::cw_t   x_r    [ITER];
  qslerp_pkg::cw_t   y_r    [ITER];
  qslerp_pkg::cw_t   z_r    [ITER];
  logic              vld_r  [ITER];
  qslerp_pkg::side_t side_r [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    qslerp_pkg::cw_t   x_in;
    qslerp_pkg::cw_t   y_in;
    qslerp_pkg::cw_t   z_in;
    logic              vld_in;
    qslerp_pkg::side_t side_in;
    qslerp_pkg::cw_t   atan_i;
    qslerp_pkg::cw_t   x_nxt;
    qslerp_pkg::cw_t   y_nxt;
    qslerp_pkg::cw_t   z_nxt;

    if (i == 0) begin : g_first
      assign x_in    = in_x;
      assign y_in    = in_y;
      assign z_in    = '0;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
      assign vld_in  = vld_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign atan_i = qslerp_pkg::cw_t'(qslerp_pkg::ATAN_Q30[i]);

    // drive y toward zero
    always_comb begin
      if (y_in >= 0) begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + atan_i;
      end else begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - atan_i;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      x_r[i]    <= x_nxt;
      y_r[i]    <= y_nxt;
      z_r[i]    <= z_nxt;
      side_r[i] <= side_in;
    end
  end

  assign out_valid = vld_r[ITER-1];
  assign out_z     = z_r[ITER-1];
  assign out_side  = side_r[ITER-1];

endmodule

// ===== hw/rtl/qslerp_rcordic.sv =====
`timescale 1ns / 1ps
// Three-lane rotation CORDIC, one micro-rotation per stage; gives gain-scaled sines.
// Depends on qslerp_pkg.
module qslerp_rcordic #(
  parameter int ITER = qslerp_pkg::TRIG_ITER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  qslerp_pkg::cw_t   in_z [3],
  input  qslerp_pkg::side_t in_side,
  output logic              out_valid,
  output qslerp_pkg::cw_t   out_y [3],
  output qslerp_pkg::side_t out_side
);

  localparam qslerp_pkg::cw_t X_INIT = qslerp_pkg::cw_t'(1) <<< qslerp_pkg::CORDIC_FRAC;

  qslerp_pkg::cw_t   x_r    [ITER][3];
  qslerp_pkg::cw_t   y_r    [ITER][3];
  qslerp_pkg::cw_t   z_r    [ITER][3];
  logic              vld_r  [ITER];
  qslerp_pkg::side_t side_r [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    qslerp_pkg::cw_t atan_i;
    assign atan_i = qslerp_pkg::cw_t'(qslerp_pkg::ATAN_Q30[i]);

    for (genvar l = 0; l < 3; l++) begin : g_lane
      qslerp_pkg::cw_t x_in;
      qslerp_pkg::cw_t y_in;
      qslerp_pkg::cw_t z_in;
      qslerp_pkg::cw_t x_nxt;
      qslerp_pkg::cw_t y_nxt;
      qslerp_pkg::cw_t z_nxt;

      if (i == 0) begin : g_first
        assign x_in = X_INIT;
        assign y_in = '0;
        assign z_in = in_z[l];
      end else begin : g_next
        assign x_in = x_r[i-1][l];
        assign y_in = y_r[i-1][l];
        assign z_in = z_r[i-1][l];
      end

      // drive the residual angle toward zero
      always_comb begin
        if (z_in >= 0) begin
          x_nxt = x_in - (y_in >>> i);
          y_nxt = y_in + (x_in >>> i);
          z_nxt = z_in - atan_i;
        end else begin
          x_nxt = x_in + (y_in >>> i);
          y_nxt = y_in - (x_in >>> i);
          z_nxt = z_in + atan_i;
        end
      end

      always_ff @(posedge clk) begin
        x_r[i][l] <= x_nxt;
        y_r[i][l] <= y_nxt;
        z_r[i][l] <= z_nxt;
      end
    end

    if (i == 0) begin : g_ctl_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else begin
          vld_r[i] <= in_valid;
        end
        side_r[i] <= in_side;
      end
    end else begin : g_ctl_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else begin
          vld_r[i] <= vld_r[i-1];
        end
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[ITER-1];
  assign out_side  = side_r[ITER-1];
  assign out_y[0]  = y_r[ITER-1][0];
  assign out_y[1]  = y_r[ITER-1][1];
  assign out_y[2]  = y_r[ITER-1][2];

endmodule

// ===== hw/rtl/qslerp_div.sv =====
`timescale 1ns / 1ps
// Four-lane restoring divider; overflow detect, then one quotient bit per stage.
// Depends on qslerp_pkg.
module qslerp_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [qslerp_pkg::DIV_NUM_W-1:0]    in_num [qslerp_pkg::LANES],
  input  logic [qslerp_pkg::LANES-1:0]        in_neg,
  input  logic [qslerp_pkg::DEN_W-1:0]        in_den,
  input  qslerp_pkg::side_t                   in_side,
  output logic                                out_valid,
  output logic [qslerp_pkg::QUOT_W-1:0]       out_quot [qslerp_pkg::LANES],
  output logic [qslerp_pkg::LANES-1:0]        out_ovf,
  output logic [qslerp_pkg::LANES-1:0]        out_neg,
  output qslerp_pkg::side_t                   out_side
);

  localparam int NW = qslerp_pkg::DIV_NUM_W;
  localparam int QW = qslerp_pkg::QUOT_W;
  localparam int DW = qslerp_pkg::DEN_W;
  localparam int L  = qslerp_pkg::LANES;
  localparam int NS = qslerp_pkg::DIV_STAGES;

  logic [NW-1:0]     rem_r  [NS][L];
  logic [QW-1:0]     quot_r [NS][L];
  logic [L-1:0]      ovf_r  [NS];
  logic [L-1:0]      neg_r  [NS];
  logic [DW-1:0]     den_r  [NS];
  logic              vld_r  [NS];
  qslerp_pkg::side_t side_r [NS];

  // first stage: flag quotients that do not fit in QW bits
  logic [L-1:0] ovf_nxt;
  always_comb begin
    for (int k = 0; k < L; k++) begin
      ovf_nxt[k] = in_num[k] >= (NW'(in_den) << QW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    for (int k = 0; k < L; k++) begin
      rem_r[0][k]  <= in_num[k];
      quot_r[0][k] <= '0;
    end
    ovf_r[0]  <= ovf_nxt;
    neg_r[0]  <= in_neg;
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    localparam int KB = NS - 1 - s;
    logic [NW-1:0] dsh;
    logic [NW-1:0] rem_nxt  [L];
    logic [QW-1:0] quot_nxt [L];

    assign dsh = NW'(den_r[s-1]) << KB;

    always_comb begin
      for (int k = 0; k < L; k++) begin
        quot_nxt[k] = quot_r[s-1][k];
        if (rem_r[s-1][k] >= dsh) begin
          rem_nxt[k]      = rem_r[s-1][k] - dsh;
          quot_nxt[k][KB] = 1'b1;
        end else begin
          rem_nxt[k] = rem_r[s-1][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
      for (int k = 0; k < L; k++) begin
        rem_r[s][k]  <= rem_nxt[k];
        quot_r[s][k] <= quot_nxt[k];
      end
      ovf_r[s]  <= ovf_r[s-1];
      neg_r[s]  <= neg_r[s-1];
      den_r[s]  <= den_r[s-1];
      side_r[s] <= side_r[s-1];
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_ovf   = ovf_r[NS-1];
  assign out_neg   = neg_r[NS-1];
  assign out_side  = side_r[NS-1];
  for (genvar k = 0; k < L; k++) begin : g_out
    assign out_quot[k] = quot_r[NS-1][k];
  end

endmodule

// ===== hw/rtl/quaternion_slerp_interpolator.sv =====
`timescale 1ns / 1ps
// Quaternion slerp top level: dot product, acos, sines, divide and saturate.
// Depends on qslerp_pkg, qslerp_isqrt, qslerp_vcordic, qslerp_rcordic, qslerp_div.
//
// Fully pipelined slerp: a request (start high while busy is low) is accepted
// on every clock cycle, and its result appears on out_res with a one-cycle
// out_valid strobe at the end of the pipeline, which is made of four front
// stages (product, dot sum, round of |d|, square), fifteen square-root stages,
// TRIG_ITERATIONS vectoring CORDIC stages for acos, two angle stages,
// TRIG_ITERATIONS three-lane rotation CORDIC stages for the sines, two
// numerator stages, seventeen divider stages and the output register. Results
// are strobed out in request order and cannot be held off; the receiver must
// take them as they come. busy is high only while reset is asserted.
// Configuration writes are applied at once and must be made while no request
// is in flight.
module quaternion_slerp_interpolator #(
  parameter int TRIG_ITERATIONS = qslerp_pkg::TRIG_ITER_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  qslerp_pkg::in_t               in_req,
  output logic                          out_valid,
  output qslerp_pkg::out_t              out_res,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [qslerp_pkg::THR_W-1:0]  cfg_wdata
);

  localparam int F       = qslerp_pkg::COMP_FRAC_BITS;
  localparam int L       = qslerp_pkg::LANES;
  localparam int CW      = qslerp_pkg::CORDIC_W;
  localparam int RW      = 2 * F + 2;
  localparam int DOT_W   = 2 * F + 6;
  localparam int UP      = qslerp_pkg::CORDIC_FRAC - F;
  localparam int TW      = qslerp_pkg::THETA_W;
  localparam int FW      = qslerp_pkg::FRAC_W;
  localparam int SW      = qslerp_pkg::SINE_W;
  localparam int PW      = 16 + SW;
  localparam int NW      = qslerp_pkg::DIV_NUM_W;
  localparam int DW      = qslerp_pkg::DEN_W;
  localparam int QW      = qslerp_pkg::QUOT_W;
  localparam int DSW     = qslerp_pkg::DIST_W;
  localparam int LATENCY = 4 + (F + 1) + 2 * TRIG_ITERATIONS + 4
                           + qslerp_pkg::DIV_STAGES + 1;
  localparam logic [F:0] ONE = (F + 1)'(1) << F;

  // ---------------------------------------------------------------- config
  logic [qslerp_pkg::THR_W-1:0] small_thr_r;
  logic [qslerp_pkg::THR_W-1:0] par_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_thr_r <= qslerp_pkg::THR_RESET;
      par_thr_r   <= qslerp_pkg::THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qslerp_pkg::CFG_SMALL_ANGLE: small_thr_r <= cfg_wdata;
        qslerp_pkg::CFG_PARALLEL:    par_thr_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Take a request every cycle outside reset.
  logic in_acc;
  assign busy   = ~rst_n;
  assign in_acc = start & ~busy;

  // ---------------------------------------------------- stage 1: products
  qslerp_pkg::side_t side1_nxt;
  qslerp_pkg::side_t side1_r;
  logic              v1_r;
  logic signed [2*16-1:0] prod1_r [L];

  always_comb begin
    side1_nxt       = '0;
    side1_nxt.qa[0] = in_req.start_x;
    side1_nxt.qa[1] = in_req.start_y;
    side1_nxt.qa[2] = in_req.start_z;
    side1_nxt.qa[3] = in_req.start_w;
    side1_nxt.qb[0] = in_req.end_x;
    side1_nxt.qb[1] = in_req.end_y;
    side1_nxt.qb[2] = in_req.end_z;
    side1_nxt.qb[3] = in_req.end_w;
    // clamp t at one
    side1_nxt.frac  = (in_req.fraction > qslerp_pkg::FRAC_ONE) ? qslerp_pkg::FRAC_ONE
                                                                : in_req.fraction;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
    end
    side1_r <= side1_nxt;
    for (int k = 0; k < L; k++) begin
      prod1_r[k] <= $signed(side1_nxt.qa[k]) * $signed(side1_nxt.qb[k]);
    end
  end

  // -------------------------------------------------- stage 2: dot product
  logic signed [DOT_W-1:0] dot2_nxt;
  logic signed [DOT_W-1:0] dot2_r;
  qslerp_pkg::side_t       side2_r;
  logic                    v2_r;

  always_comb begin
    dot2_nxt = '0;
    for (int k = 0; k < L; k++) begin
      dot2_nxt = dot2_nxt + DOT_W'(prod1_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    dot2_r  <= dot2_nxt;
    side2_r <= side1_r;
  end

  // ------------------------------------------- stage 3: round and clamp |d|
  logic [DOT_W-1:0]  mag3;
  logic [DOT_W-1:0]  rnd3;
  logic [DOT_W-F-1:0] ad3;
  qslerp_pkg::side_t side3_nxt;
  qslerp_pkg::side_t side3_r;
  logic              v3_r;

  always_comb begin
    mag3      = (dot2_r < 0) ? DOT_W'(-dot2_r) : DOT_W'(dot2_r);
    rnd3      = mag3 + (DOT_W'(1) << (F - 1));
    ad3       = rnd3[DOT_W-1:F];
    side3_nxt = side2_r;
    side3_nxt.neg = dot2_r < 0;
    side3_nxt.mag = (ad3 > (DOT_W - F)'(ONE)) ? ONE : ad3[F:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    side3_r <= side3_nxt;
  end

  // -------------------------------- stage 4: square and parallel detect
  logic [RW-1:0]     sq4_r;
  qslerp_pkg::side_t side4_nxt;
  qslerp_pkg::side_t side4_r;
  logic              v4_r;
  logic [RW-1:0]     rad4;

  always_comb begin
    side4_nxt     = side3_r;
    // nearly parallel: distance forced to zero
    side4_nxt.par = ((F + 2)'(side3_r.mag) + (F + 2)'(par_thr_r)) > (F + 2)'(ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    sq4_r   <= RW'(side3_r.mag) * RW'(side3_r.mag);
    side4_r <= side4_nxt;
  end

  assign rad4 = (RW'(1) << (2 * F)) - sq4_r;

  // ------------------------------------------- sqrt(1 - d^2), then acos
  logic              v_iq;
  logic [F:0]        root_iq;
  qslerp_pkg::side_t side_iq;

  qslerp_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_rad    (rad4),
    .in_side   (side4_r),
    .out_valid (v_iq),
    .out_root  (root_iq),
    .out_side  (side_iq)
  );

  qslerp_pkg::cw_t   vx0;
  qslerp_pkg::cw_t   vy0;
  logic              v_vc;
  qslerp_pkg::cw_t   z_vc;
  qslerp_pkg::side_t side_vc;

  assign vx0 = qslerp_pkg::cw_t'(side_iq.mag) <<< UP;
  assign vy0 = qslerp_pkg::cw_t'(root_iq) <<< UP;

  qslerp_vcordic #(
    .ITER (TRIG_ITERATIONS)
  ) u_vcordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_iq),
    .in_x      (vx0),
    .in_y      (vy0),
    .in_side   (side_iq),
    .out_valid (v_vc),
    .out_z     (z_vc),
    .out_side  (side_vc)
  );

  // ------------------------------- stage A: distance, theta, small angle
  qslerp_pkg::cw_t   acos_a;
  logic [CW-1:0]     dsum_a;
  logic [CW-1:0]     tsum_a;
  logic [DSW:0]      dist_a;
  logic [TW-1:0]     theta_a;
  logic [TW-1:0]     theta_a_r;
  qslerp_pkg::side_t side_a_nxt;
  qslerp_pkg::side_t side_a_r;
  logic              va_r;

  always_comb begin
    // clamp the angle at zero; parallel inputs give zero
    acos_a  = (side_vc.par || z_vc < 0) ? '0 : z_vc;
    dsum_a  = CW'(acos_a) + (CW'(1) << 15);
    tsum_a  = CW'(acos_a) + (CW'(1) << 16);
    dist_a  = dsum_a[DSW+16:16];
    theta_a = tsum_a[TW+16:17];
    side_a_nxt          = side_vc;
    side_a_nxt.rot_dist = (dist_a > (DSW + 1)'(15'h7FFF)) ? 15'h7FFF : dist_a[DSW-1:0];
    side_a_nxt.copy     = theta_a <= TW'(small_thr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= v_vc;
    end
    theta_a_r <= theta_a;
    side_a_r  <= side_a_nxt;
  end

  // ----------------------------- stage B: angles t*theta, (1-t)*theta
  logic [FW-1:0]        tc_b;
  logic [FW+TW-1:0]     p0_b;
  logic [FW+TW-1:0]     p1_b;
  qslerp_pkg::cw_t      zb_r [3];
  qslerp_pkg::side_t    side_b_r;
  logic                 vb_r;

  always_comb begin
    tc_b = qslerp_pkg::FRAC_ONE - side_a_r.frac;
    p0_b = (FW + TW)'(tc_b) * (FW + TW)'(theta_a_r);
    p1_b = (FW + TW)'(side_a_r.frac) * (FW + TW)'(theta_a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    zb_r[0]  <= qslerp_pkg::cw_t'(theta_a_r) <<< 17;
    zb_r[1]  <= qslerp_pkg::cw_t'(p0_b) <<< 1;
    zb_r[2]  <= qslerp_pkg::cw_t'(p1_b) <<< 1;
    side_b_r <= side_a_r;
  end

  // ----------------------------------------------------------- sines
  logic              v_rc;
  qslerp_pkg::cw_t   y_rc [3];
  qslerp_pkg::side_t side_rc;

  qslerp_rcordic #(
    .ITER (TRIG_ITERATIONS)
  ) u_rcordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r),
    .in_z      (zb_r),
    .in_side   (side_b_r),
    .out_valid (v_rc),
    .out_y     (y_rc),
    .out_side  (side_rc)
  );

  // ------------------------------------------- stage C: weighted terms
  qslerp_pkg::cw_t     s1n_c;
  logic signed [SW-1:0] s0_c;
  logic signed [SW-1:0] s1_c;
  qslerp_pkg::side_t   side_c_nxt;
  qslerp_pkg::side_t   side_c_r;
  logic signed [PW-1:0] pa_c_r [L];
  logic signed [PW-1:0] pb_c_r [L];
  logic [DW-1:0]       sth_c_r;
  logic                vc_r;

  always_comb begin
    // negate the end term for the short arc
    s1n_c = side_rc.neg ? -y_rc[2] : y_rc[2];
    s0_c  = y_rc[1][SW-1:0];
    s1_c  = s1n_c[SW-1:0];
    side_c_nxt      = side_rc;
    // degenerate sine of theta: copy the start
    side_c_nxt.copy = side_rc.copy | (y_rc[0] <= 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= v_rc;
    end
    for (int k = 0; k < L; k++) begin
      pa_c_r[k] <= $signed(side_rc.qa[k]) * s0_c;
      pb_c_r[k] <= $signed(side_rc.qb[k]) * s1_c;
    end
    sth_c_r  <= y_rc[0][DW-1:0];
    side_c_r <= side_c_nxt;
  end

  // ------------------------------- stage D: numerator magnitude + half
  logic signed [PW:0]  num_d [L];
  logic [PW:0]         mag_d [L];
  logic [NW-1:0]       n_d_nxt [L];
  logic [L-1:0]        neg_d_nxt;
  logic [NW-1:0]       n_d_r [L];
  logic [L-1:0]        neg_d_r;
  logic [DW-1:0]       sth_d_r;
  qslerp_pkg::side_t   side_d_r;
  logic                vd_r;

  always_comb begin
    for (int k = 0; k < L; k++) begin
      num_d[k]     = (PW + 1)'(pa_c_r[k]) + (PW + 1)'(pb_c_r[k]);
      neg_d_nxt[k] = num_d[k] < 0;
      mag_d[k]     = neg_d_nxt[k] ? (PW + 1)'(-num_d[k]) : (PW + 1)'(num_d[k]);
      n_d_nxt[k]   = NW'(mag_d[k]) + NW'(sth_c_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
    for (int k = 0; k < L; k++) begin
      n_d_r[k] <= n_d_nxt[k];
    end
    neg_d_r  <= neg_d_nxt;
    sth_d_r  <= sth_c_r;
    side_d_r <= side_c_r;
  end

  // ---------------------------------------------------------- divide
  logic              v_dv;
  logic [QW-1:0]     q_dv [L];
  logic [L-1:0]      ovf_dv;
  logic [L-1:0]      neg_dv;
  qslerp_pkg::side_t side_dv;

  qslerp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vd_r),
    .in_num    (n_d_r),
    .in_neg    (neg_d_r),
    .in_den    (sth_d_r),
    .in_side   (side_d_r),
    .out_valid (v_dv),
    .out_quot  (q_dv),
    .out_ovf   (ovf_dv),
    .out_neg   (neg_dv),
    .out_side  (side_dv)
  );

  // ------------------------------------- output: saturate or copy start
  logic [15:0]       comp_o [L];
  qslerp_pkg::out_t  out_nxt;
  qslerp_pkg::out_t  out_res_r;
  logic              out_valid_r;

  always_comb begin
    for (int k = 0; k < L; k++) begin
      if (side_dv.copy) begin
        comp_o[k] = side_dv.qa[k];
      end else if (neg_dv[k]) begin
        comp_o[k] = (ovf_dv[k] || q_dv[k] > 16'h8000) ? 16'h8000 : (16'h0 - q_dv[k]);
      end else begin
        comp_o[k] = (ovf_dv[k] || q_dv[k] > 16'h7FFF) ? 16'h7FFF : q_dv[k];
      end
    end
    out_nxt.out_x             = comp_o[0];
    out_nxt.out_y             = comp_o[1];
    out_nxt.out_z             = comp_o[2];
    out_nxt.out_w             = comp_o[3];
    out_nxt.rotation_distance = side_dv.rot_dist;
    out_nxt.copied_start      = side_dv.copy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_dv;
    end
    out_res_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // ------------------------------------------------------- assertions
  a_reset_drops_results: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe survived reset");

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a request at pipeline depth");

  a_zero_distance_copies: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.rotation_distance == 0) |-> out_res.copied_start)
    else $error("zero distance did not copy the start quaternion");

endmodule
